@@ rtl/serial_command_line_editor_defines.svh @@
// Assertion macros shared by the checker of the serial command line editor.
// Holds only macro definitions; no other file is needed to use it.
`ifndef SERIAL_COMMAND_LINE_EDITOR_DEFINES_SVH
`define SERIAL_COMMAND_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/scle_pkg.sv @@
// Shared types and constants of the serial command line editor.
// No dependencies; used by every module of the block.
package scle_pkg;

   localparam int LINE_BUF_DEPTH_DEF = 256;

   // Operation codes of an input word.
   localparam logic [1:0] OP_RX    = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Terminal characters.
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // What the result register is sending.
   typedef enum logic [1:0] {
      RSP_READ,
      RSP_ECHO,
      RSP_ERASE,
      RSP_EOL
   } rsp_kind_type;

   // Handed from the line decoder to the result sequencer.
   typedef struct packed {
      logic         valid;
      rsp_kind_type kind;
      logic [7:0]   ch;
      logic [7:0]   length;
      logic         out_of_range;
   } rsp_load_type;

endpackage

@@ rtl/serial_command_line_editor.sv @@
// Top level of the serial command line editor.
// Depends on scle_pkg, scle_ram, scle_decode and scle_rsp.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   op, rx_char, read_index
//   rsp_      out        rsp_valid/rsp_stall   out_char, echo_valid, line_done,
//                                              line_length, last
//
// An accepted input word loads its results into the result register at the
// next edge; they leave one word per cycle while rsp_stall is low. A word
// with no result sends nothing, any other one word, a line end two (CR, LF)
// and a backspace three (BS, space, BS), all from the single result register.
// Reset is synchronous and clears the character count and the CR flag and
// empties the result register; the line buffer is not cleared. A stall on the
// result side holds the result and stalls the input side once the result
// register has a word that must stay.
module serial_command_line_editor #(
   parameter int LINE_BUF_DEPTH = scle_pkg::LINE_BUF_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_rx_char,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_echo_valid,
   output logic       rsp_line_done,
   output logic [7:0] rsp_line_length,
   output logic       rsp_last
);

   localparam int ADDR_W = $clog2(LINE_BUF_DEPTH);

   logic                   accept;
   logic                   buf_wr_en;
   logic [ADDR_W-1:0]      buf_wr_addr;
   logic [7:0]             buf_wr_data;
   logic                   buf_rd_en;
   logic [ADDR_W-1:0]      buf_rd_addr;
   logic [7:0]             buf_rd_data;
   scle_pkg::rsp_load_type load;

   // A word is taken whenever the result register can make room for it.
   assign accept = req_valid && !req_stall;

   // Decoder: updates the count and CR flag and drives buffer accesses in
   // the cycle the word is accepted.
   scle_decode #(
      .LINE_BUF_DEPTH(LINE_BUF_DEPTH)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_op        (req_op),
      .req_rx_char   (req_rx_char),
      .req_read_index(req_read_index),
      .buf_wr_en     (buf_wr_en),
      .buf_wr_addr   (buf_wr_addr),
      .buf_wr_data   (buf_wr_data),
      .buf_rd_en     (buf_rd_en),
      .buf_rd_addr   (buf_rd_addr),
      .load          (load)
   );

   // Line buffer. Its read data register only changes when a read word is
   // accepted, so it holds steady while that read result waits.
   scle_ram #(
      .WIDTH(8),
      .DEPTH(LINE_BUF_DEPTH)
   ) u_line_buf (
      .clock  (clock),
      .wr_en  (buf_wr_en),
      .wr_addr(buf_wr_addr),
      .wr_data(buf_wr_data),
      .rd_en  (buf_rd_en),
      .rd_addr(buf_rd_addr),
      .rd_data(buf_rd_data)
   );

   // Result register and word sequencer for echo, erase and line end.
   scle_rsp u_rsp (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .load           (load),
      .buf_rd_data    (buf_rd_data),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_line_done  (rsp_line_done),
      .rsp_line_length(rsp_line_length),
      .rsp_last       (rsp_last)
   );

endmodule

@@ rtl/scle_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on scle_pkg for the default depth.
module scle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = scle_pkg::LINE_BUF_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/scle_decode.sv @@
// Line state of the editor: character count, CR flag and buffer accesses.
// Depends on scle_pkg.
module scle_decode #(
   parameter int LINE_BUF_DEPTH = scle_pkg::LINE_BUF_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        req_op,
   input  logic [7:0]                        req_rx_char,
   input  logic [7:0]                        req_read_index,
   output logic                              buf_wr_en,
   output logic [$clog2(LINE_BUF_DEPTH)-1:0] buf_wr_addr,
   output logic [7:0]                        buf_wr_data,
   output logic                              buf_rd_en,
   output logic [$clog2(LINE_BUF_DEPTH)-1:0] buf_rd_addr,
   output scle_pkg::rsp_load_type            load
);

   localparam int CNT_W = $clog2(LINE_BUF_DEPTH);
   localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;
   localparam int CMP_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             cr_seen_ff, cr_seen_in;
   logic [CMP_W-1:0] index_ext;
   logic [LEN_W-1:0] length_ext;
   logic             line_full;

   assign index_ext  = CMP_W'(req_read_index);
   assign line_full  = (count_ff == CNT_W'(LINE_BUF_DEPTH - 1));
   assign length_ext = LEN_W'(count_in);

   always_comb begin
      count_in          = count_ff;
      cr_seen_in        = cr_seen_ff;
      buf_wr_en         = 1'b0;
      buf_wr_addr       = count_ff;
      buf_wr_data       = req_rx_char;
      buf_rd_en         = 1'b0;
      buf_rd_addr       = index_ext[CNT_W-1:0];
      load.valid        = 1'b0;
      load.kind         = scle_pkg::RSP_ECHO;
      load.ch           = req_rx_char;
      load.out_of_range = (index_ext >= CMP_W'(LINE_BUF_DEPTH));
      if (accept) begin
         unique case (req_op)
            scle_pkg::OP_READ: begin
               buf_rd_en  = 1'b1;
               load.valid = 1'b1;
               load.kind  = scle_pkg::RSP_READ;
            end
            scle_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            scle_pkg::OP_RX: begin
               if (req_rx_char == scle_pkg::CH_BS) begin
                  // Backspace on an empty line does nothing at all.
                  if (count_ff != '0) begin
                     count_in   = count_ff - CNT_W'(1);
                     load.valid = 1'b1;
                     load.kind  = scle_pkg::RSP_ERASE;
                  end
               end else if (req_rx_char == scle_pkg::CH_LF && cr_seen_ff) begin
                  cr_seen_in = 1'b0;
               end else if (req_rx_char == scle_pkg::CH_CR ||
                            req_rx_char == scle_pkg::CH_LF ||
                            req_rx_char == scle_pkg::CH_ESC) begin
                  if (req_rx_char == scle_pkg::CH_CR) begin
                     cr_seen_in = 1'b1;
                  end
                  buf_wr_en   = 1'b1;
                  buf_wr_data = '0;
                  load.valid  = 1'b1;
                  load.kind   = scle_pkg::RSP_EOL;
               end else if (!line_full) begin
                  buf_wr_en  = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
                  load.valid = 1'b1;
                  load.kind  = scle_pkg::RSP_ECHO;
               end
            end
            default: begin
            end
         endcase
      end
      load.length = length_ext[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cr_seen_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cr_seen_ff <= cr_seen_in;
      end
   end

endmodule

@@ rtl/scle_rsp.sv @@
// Result register of the editor: sends the one to three words of an item.
// Depends on scle_pkg.
module scle_rsp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  scle_pkg::rsp_load_type load,
   input  logic [7:0]             buf_rd_data,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_echo_valid,
   output logic                   rsp_line_done,
   output logic [7:0]             rsp_line_length,
   output logic                   rsp_last
);

   logic                   valid_ff, valid_in;
   logic [1:0]             step_ff, step_in;
   scle_pkg::rsp_kind_type kind_ff, kind_in;
   logic [7:0]             char_ff, char_in;
   logic [7:0]             length_ff, length_in;
   logic                   oor_ff, oor_in;
   logic                   last_word;
   logic                   take;

   always_comb begin
      rsp_out_char  = char_ff;
      last_word     = 1'b1;
      rsp_line_done = 1'b0;
      unique case (kind_ff)
         scle_pkg::RSP_READ: begin
            rsp_out_char = oor_ff ? '0 : buf_rd_data;
         end
         scle_pkg::RSP_ECHO: begin
            rsp_out_char = char_ff;
         end
         scle_pkg::RSP_ERASE: begin
            rsp_out_char = (step_ff == 2'd1) ? scle_pkg::CH_SPACE : scle_pkg::CH_BS;
            last_word    = (step_ff == 2'd2);
         end
         scle_pkg::RSP_EOL: begin
            rsp_out_char  = (step_ff == 2'd0) ? scle_pkg::CH_CR : scle_pkg::CH_LF;
            last_word     = (step_ff == 2'd1);
            rsp_line_done = (step_ff == 2'd1);
         end
         default: begin
         end
      endcase
   end

   assign take      = valid_ff && !rsp_stall;
   // A new word may enter when the register is empty or its final word leaves now.
   assign req_stall = valid_ff && !(take && last_word);

   always_comb begin
      valid_in  = valid_ff;
      step_in   = step_ff;
      kind_in   = kind_ff;
      char_in   = char_ff;
      length_in = length_ff;
      oor_in    = oor_ff;
      if (accept) begin
         valid_in  = load.valid;
         step_in   = '0;
         kind_in   = load.kind;
         char_in   = load.ch;
         length_in = load.length;
         oor_in    = load.out_of_range;
      end else if (take) begin
         if (last_word) begin
            valid_in = 1'b0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      kind_ff   <= kind_in;
      char_ff   <= char_in;
      length_ff <= length_in;
      oor_ff    <= oor_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_echo_valid  = (kind_ff != scle_pkg::RSP_READ);
   assign rsp_line_length = length_ff;
   assign rsp_last        = last_word;

endmodule

@@ rtl/scle_checker.sv @@
// Port-level checks of the serial command line editor, bound to its top.
// Depends on scle_pkg and serial_command_line_editor_defines.svh.
`include "serial_command_line_editor_defines.svh"

module scle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_echo_valid,
   input logic       rsp_line_done,
   input logic       rsp_last
);

   // A line end closes with an echoed LF as the final word.
   `SCLE_ASSERT_NOW(a_done_is_final_lf, clock, reset, rsp_valid && rsp_line_done,
                    rsp_last && rsp_echo_valid && rsp_out_char == scle_pkg::CH_LF,
                    "line_done not on final LF echo")

   // Words of one item follow each other without a gap.
   `SCLE_ASSERT_NEXT(a_burst_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last,
                     rsp_valid, "gap inside a result burst")

   // No new word enters while the current item still has words to send.
   `SCLE_ASSERT_NOW(a_hold_input, clock, reset, rsp_valid && !rsp_last, req_stall,
                    "input taken during a result burst")

   // A stalled result stays put.
   `SCLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_out_char) && $stable(rsp_last),
                     "stalled result changed")

endmodule

bind serial_command_line_editor scle_checker u_scle_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_char  (rsp_out_char),
   .rsp_echo_valid(rsp_echo_valid),
   .rsp_line_done (rsp_line_done),
   .rsp_last      (rsp_last)
);
